[design/pida_pkg.sv]
// ============================================================================
// pida_pkg
// Shared types and constants for the positional insert/delete array.
// ============================================================================
package pida_pkg;

  // Number of element slots and derived widths
  localparam int unsigned Depth  = 32;
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam int unsigned ElemW  = 32;

  // Operation codes
  typedef enum logic [2:0] {
    OP_CLEAR  = 3'd0,
    OP_APPEND = 3'd1,
    OP_INSERT = 3'd2,
    OP_DELETE = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  // Status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  // Input beat
  typedef struct packed {
    logic [2:0]        operation;
    logic [4:0]        position;
    logic signed [31:0] value;
  } in_t;

  // Output beat
  typedef struct packed {
    logic signed [31:0] result_value;
    logic [5:0]         element_count;
    logic [1:0]         status;
  } out_t;

  // Controller to datapath command
  typedef struct packed {
    logic exec;  // input beat accepted: apply op, load result register
  } cmd_t;

endpackage

[design/pida_ctrl.sv]
// ============================================================================
// pida_ctrl
// Handshake controller: tracks the output register and issues exec commands.
// ============================================================================
module pida_ctrl import pida_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  output cmd_t cmd_o
);

  typedef enum logic {
    S_EMPTY,
    S_HOLD
  } state_e;

  state_e state_q;
  state_e state_d;
  logic   exec;

  // Stall input only while a result sits unaccepted
  assign in_stall_o  = (state_q == S_HOLD) && out_stall_i;
  assign exec        = in_valid_i && !in_stall_o;
  assign out_valid_o = (state_q == S_HOLD);
  assign cmd_o.exec  = exec;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_EMPTY: begin
        if (exec) state_d = S_HOLD;
      end
      S_HOLD: begin
        // new beat refills the register as the old one leaves
        if (!exec && !out_stall_i) state_d = S_EMPTY;
      end
      default: state_d = S_EMPTY;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_EMPTY;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

[design/pida_dp.sv]
// ============================================================================
// pida_dp
// Datapath: element store, count, parallel shift and result register.
// ============================================================================
module pida_dp import pida_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cmd_t cmd_i,
  input  in_t  in_data_i,
  output out_t out_data_o
);

  logic [ElemW-1:0] elem_q  [Depth];
  logic [ElemW-1:0] elem_d  [Depth];
  logic [ElemW-1:0] up_src  [Depth];
  logic [ElemW-1:0] dn_src  [Depth];
  logic [CntW-1:0]  cnt_q;
  logic [CntW-1:0]  cnt_d;
  logic [CntW-1:0]  pos_w;
  logic [CntW-1:0]  ins_at;
  logic [ElemW-1:0] rd_val;
  logic [ElemW-1:0] res;
  logic [1:0]       st;
  logic             full;
  logic             empty;
  out_t             out_q;

  assign pos_w = CntW'(in_data_i.position);
  assign full  = (cnt_q == CntW'(Depth));
  assign empty = (cnt_q == '0);

  // Neighbor taps for shift up and shift down
  always_comb begin
    up_src[0]       = '0;
    dn_src[Depth-1] = '0;
    for (int k = 1; k < Depth; k++) up_src[k] = elem_q[k-1];
    for (int k = 0; k < Depth - 1; k++) dn_src[k] = elem_q[k+1];
  end

  // Read mux
  always_comb begin
    rd_val = '0;
    for (int k = 0; k < Depth; k++) begin
      if (CntW'(k) == pos_w) rd_val = elem_q[k];
    end
  end

  assign ins_at = (in_data_i.operation == OP_APPEND) ? cnt_q : pos_w;

  always_comb begin
    elem_d = elem_q;
    cnt_d  = cnt_q;
    res    = '0;
    st     = ST_OK;
    case (in_data_i.operation)
      OP_CLEAR: begin
        for (int k = 0; k < Depth; k++) elem_d[k] = '0;
        cnt_d = '0;
      end
      OP_APPEND, OP_INSERT: begin
        if (full) begin
          st = ST_FULL;
        end else if (in_data_i.operation == OP_INSERT && pos_w > cnt_q) begin
          st = ST_RANGE;
        end else begin
          // slots above count are zero, so shifting the whole tail is safe
          for (int k = 0; k < Depth; k++) begin
            if (CntW'(k) == ins_at) elem_d[k] = in_data_i.value;
            else if (CntW'(k) > ins_at) elem_d[k] = up_src[k];
          end
          cnt_d = cnt_q + 1'b1;
        end
      end
      OP_DELETE, OP_READ: begin
        if (empty) begin
          st = ST_EMPTY;
        end else if (pos_w >= cnt_q) begin
          st = ST_RANGE;
        end else begin
          res = rd_val;
          if (in_data_i.operation == OP_DELETE) begin
            for (int k = 0; k < Depth; k++) begin
              if (CntW'(k) >= pos_w) elem_d[k] = dn_src[k];
            end
            cnt_d = cnt_q - 1'b1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < Depth; k++) elem_q[k] <= '0;
      cnt_q <= '0;
    end else if (cmd_i.exec) begin
      elem_q <= elem_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.exec) begin
      out_q.result_value  <= res;
      out_q.element_count <= 6'(cnt_d);
      out_q.status        <= st;
    end
  end

  assign out_data_o = out_q;

endmodule

[design/positional_insert_delete_array.sv]
// ============================================================================
// positional_insert_delete_array
// Packed array of signed 32-bit elements with insert/delete at a position.
// ============================================================================
// The block holds up to 32 signed elements packed from slot 0 and a count.
// Each input beat is one operation (clear, append, insert at position,
// delete at position, read at position) and returns exactly one output
// beat: the deleted or read value (zero otherwise), the count after the
// operation and a status (ok, full, position out of range, empty). A
// rejected operation leaves the store untouched; unused opcodes do nothing
// and report ok. Throughput is one beat per clock: every slot loads from its
// neighbor in parallel, so the whole shift plus the 32:1 read mux completes
// in the accept cycle, and the result is presented from an output register
// the cycle after. The input stalls only while that register holds a result
// the consumer is stalling. Reset zeroes the store and count at once.
// ============================================================================
module positional_insert_delete_array import pida_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  // input channel
  input  logic in_valid_i,
  output logic in_stall_o,
  input  in_t  in_data_i,
  // output channel
  output logic out_valid_o,
  input  logic out_stall_i,
  output out_t out_data_o
);

  cmd_t cmd;

  // Handshake / sequencing
  pida_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  // Store, shift network and result register
  pida_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .out_data_o (out_data_o)
  );

  // Accepted beat always yields a result next cycle
  a_accept_to_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> out_valid_o)
    else $error("accepted beat produced no result");

  // Input back-pressure only from a held, stalled result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");

  // Full status only with a full array
  a_full_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_FULL |->
      out_data_o.element_count == 6'(Depth))
    else $error("full status with count below depth");

  // Empty status carries zero count and zero value
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.status == ST_EMPTY |->
      out_data_o.element_count == '0 && out_data_o.result_value == '0)
    else $error("empty status with nonzero count or value");

endmodule

[tb/positional_insert_delete_array_tb.sv]
// ============================================================================
// positional_insert_delete_array_tb
// Self-checking bench for the positional insert/delete array.
// ============================================================================
// Operation beats go in through the valid/stall input channel. The sender
// works in bursts with random gaps. A shadow copy of the element store and
// the count works out the result beat for each accepted operation. Result
// beats are taken under a changing stall pattern and compared field by field,
// in order, with the oldest awaited result. The run starts with a short
// hand-picked list of corner operations. Random traffic follows, in segments
// that bias the array toward filling up, draining or mixed use.
// ============================================================================
module positional_insert_delete_array_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pida_pkg::*;

  localparam int unsigned RandomOps  = 400;   // random beats after the corner list
  localparam int unsigned StuckLimit = 2000;  // cycles with no beat moving either way
  localparam int unsigned DrainTail  = 8;     // result register latency plus margin
  localparam int unsigned PosMax     = 31;    // top of the 5-bit position field

  // Opcodes 5..7 have no meaning; the block must ignore them
  localparam logic [2:0] OpUnusedFirst = OP_READ + 3'd1;
  localparam logic [2:0] OpUnusedLast  = 3'd7;

  typedef enum int unsigned {MIX_GROW = 0, MIX_SHRINK = 1, MIX_ANY = 2} mix_e;
  typedef enum int unsigned {
    STALL_NONE, STALL_SPARSE, STALL_PERIODIC, STALL_HEAVY
  } stall_style_e;

  // --------------------------------------------------------------------------
  // Shadow store: tracks elements and count, queues awaited result beats
  // --------------------------------------------------------------------------
  class array_mirror;
    logic signed [ElemW-1:0] elems [Depth];
    int unsigned             count;
    out_t                    awaited [$];
    int unsigned             errors;

    function new();
      foreach (elems[k]) elems[k] = '0;
      count  = 0;
      errors = 0;
    endfunction

    // Applies one operation to the shadow store and returns its result beat
    function out_t apply_op(in_t beat);
      out_t        res;
      int unsigned pos;
      int unsigned k;
      res = '0;
      res.status = ST_OK;
      pos = beat.position;
      case (beat.operation)
        OP_CLEAR: begin
          foreach (elems[j]) elems[j] = '0;
          count = 0;
        end
        OP_APPEND: begin
          if (count >= Depth) begin
            res.status = ST_FULL;
          end else begin
            elems[count] = beat.value;
            count++;
          end
        end
        OP_INSERT: begin
          // full check wins over the position check
          if (count >= Depth) begin
            res.status = ST_FULL;
          end else if (pos > count) begin
            res.status = ST_RANGE;
          end else begin
            for (k = count; k > pos; k--) elems[k] = elems[k-1];
            elems[pos] = beat.value;
            count++;
          end
        end
        OP_DELETE: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (pos >= count) begin
            res.status = ST_RANGE;
          end else begin
            res.result_value = elems[pos];
            for (k = pos; k + 1 < count; k++) elems[k] = elems[k+1];
            elems[count-1] = '0;
            count--;
          end
        end
        OP_READ: begin
          if (count == 0) begin
            res.status = ST_EMPTY;
          end else if (pos >= count) begin
            res.status = ST_RANGE;
          end else begin
            res.result_value = elems[pos];
          end
        end
        default: ;  // unused opcode: no change, zero result, ok status
      endcase
      res.element_count = CntW'(count);
      return res;
    endfunction

    function void note_accepted(in_t beat);
      awaited.push_back(apply_op(beat));
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH %s", $realtime, msg);
      errors++;
    endtask

    task check_result(out_t got);
      out_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result beat with nothing awaited: value=%0d count=%0d status=%0d",
                         got.result_value, got.element_count, got.status));
      end else begin
        want = awaited.pop_front();
        if (got.result_value !== want.result_value ||
            got.element_count !== want.element_count ||
            got.status !== want.status) begin
          report($sformatf("value %0d/%0d count %0d/%0d status %0d/%0d (got/want)",
                           got.result_value, want.result_value,
                           got.element_count, want.element_count,
                           got.status, want.status));
        end
      end
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, DUT
  // --------------------------------------------------------------------------
  logic clk;
  logic rst_n     = 1'b0;
  logic in_valid  = 1'b0;
  logic in_stall;
  in_t  in_data   = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_t out_data;

  array_mirror mirror = new();

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  positional_insert_delete_array DUT (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------
  int unsigned burst_left = 0;

  // Holds the beat until the block takes it; the shadow store updates on accept
  task automatic send_beat(in_t beat);
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (in_stall);
    mirror.note_accepted(beat);
  endtask

  task automatic idle_for(int unsigned cycles);
    in_valid <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // Burst pacing: a new burst may start after a random gap; some bursts are long
  task automatic paced_send(in_t beat);
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 16);
      if ($urandom_range(0, 4) != 0) idle_for($urandom_range(1, 10));
    end
    burst_left--;
    send_beat(beat);
  endtask

  // Stops sending until every awaited result beat has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (mirror.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic in_t beat_of(logic [2:0] op, logic [4:0] pos, logic signed [31:0] val);
    in_t beat;
    beat.operation = op;
    beat.position  = pos;
    beat.value     = val;
    return beat;
  endfunction

  // Mostly random data, with the edges of the signed range mixed in
  function automatic logic signed [31:0] pick_value();
    logic signed [31:0] edges [5];
    edges = '{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh0, -32'sd1, 32'sd1};
    if ($urandom_range(0, 99) < 12) return edges[$urandom_range(0, 4)];
    return $urandom;
  endfunction

  // Builds one random operation, biased by the segment's mix, with positions
  // aimed mostly inside the live range so shifts actually happen
  function automatic in_t make_op(mix_e mix);
    op_e         op_menu [5];
    int unsigned weights [6];
    in_t         beat;
    int unsigned roll;
    int unsigned pick;
    int unsigned acc;
    int unsigned cnt;
    int unsigned lim;
    op_menu = '{OP_CLEAR, OP_APPEND, OP_INSERT, OP_DELETE, OP_READ};
    case (mix)
      MIX_GROW:   weights = '{1, 40, 44, 5, 7, 3};
      MIX_SHRINK: weights = '{1, 5, 10, 55, 25, 4};
      default:    weights = '{4, 18, 20, 20, 20, 18};
    endcase
    cnt  = mirror.count;
    roll = $urandom_range(0, 99);
    pick = 0;
    acc  = weights[0];
    while (roll >= acc) begin
      pick++;
      acc += weights[pick];
    end
    beat.value = pick_value();
    if (pick < 5) beat.operation = op_menu[pick];
    else beat.operation = 3'($urandom_range(OpUnusedFirst, OpUnusedLast));

    // insert may land at count; delete and read only below it
    lim = (beat.operation == OP_INSERT) ? cnt : ((cnt == 0) ? 0 : cnt - 1);
    if (lim > PosMax) lim = PosMax;
    roll = $urandom_range(0, 99);
    if (roll < 70) beat.position = 5'($urandom_range(0, lim));
    else if (roll < 80 && cnt <= PosMax) beat.position = 5'(cnt);
    else beat.position = 5'($urandom);
    return beat;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_t         beat;
    mix_e        mix;
    int unsigned ops_sent;
    int unsigned seg;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Corner operations on a small array
    paced_send(beat_of(OP_READ,   5'd0,  32'sd7));            // read on empty
    paced_send(beat_of(OP_DELETE, 5'd0,  32'sd7));            // delete on empty
    paced_send(beat_of(OP_INSERT, 5'd1,  32'sd9));            // insert past count
    paced_send(beat_of(OP_INSERT, 5'd0,  32'sh8000_0000));    // most negative
    paced_send(beat_of(OP_APPEND, 5'd31, 32'sh7FFF_FFFF));    // most positive
    paced_send(beat_of(OP_APPEND, 5'd0,  -32'sd1));
    paced_send(beat_of(OP_INSERT, 5'd3,  32'sh0));            // at count: acts as append
    paced_send(beat_of(OP_INSERT, 5'd1,  32'sh5555_5555));    // middle, shifts up
    paced_send(beat_of(OP_INSERT, 5'd0,  32'shAAAA_AAAA));    // head, shifts all
    paced_send(beat_of(OP_READ,   5'd0,  32'sd0));
    paced_send(beat_of(OP_READ,   5'd5,  32'sd0));            // last live slot
    paced_send(beat_of(OP_READ,   5'd6,  32'sd0));            // at count: out of range
    paced_send(beat_of(OP_READ,   5'd31, 32'sd0));
    paced_send(beat_of(OP_DELETE, 5'd31, 32'sd0));
    paced_send(beat_of(OP_DELETE, 5'd0,  32'sd0));            // head, shifts all down
    paced_send(beat_of(OP_DELETE, 5'd4,  32'sd0));            // tail
    paced_send(beat_of(OP_DELETE, 5'd1,  32'sd0));            // middle
    paced_send(beat_of(OpUnusedFirst, 5'd31, 32'sh7FFF_FFFF));
    paced_send(beat_of(OpUnusedLast,  5'd0,  -32'sd1));
    paced_send(beat_of(OP_CLEAR,  5'd0,  32'sd0));
    paced_send(beat_of(OP_READ,   5'd0,  32'sd0));            // empty again after clear
    paced_send(beat_of(OP_APPEND, 5'd0,  32'sd1));
    paced_send(beat_of(OP_CLEAR,  5'd31, -32'sd1));           // clear ignores its fields

    // Hold off until the directed results are all back
    wait_drained();

    // Random segments; every third one biases the array toward filling up
    ops_sent = 0;
    seg      = 0;
    while (ops_sent < RandomOps) begin
      mix = (seg % 3 == 0) ? MIX_GROW : mix_e'($urandom_range(MIX_SHRINK, MIX_ANY));
      repeat ($urandom_range(30, 60)) begin
        if (ops_sent < RandomOps) begin
          beat = make_op(mix);
          paced_send(beat);
          ops_sent++;
        end
      end
      if ($urandom_range(0, 2) == 0) wait_drained();
      seg++;
    end

    wait_drained();
    repeat (DrainTail) @(posedge clk);
    if (mirror.errors == 0 && mirror.awaited.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // --------------------------------------------------------------------------
  // Receiver: checks each accepted result beat, stalls in changing styles
  // --------------------------------------------------------------------------
  stall_style_e stall_style  = STALL_NONE;
  int unsigned  stall_window = 0;

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) mirror.check_result(out_data);
    if (stall_window == 0) begin
      stall_style  = stall_style_e'($urandom_range(STALL_NONE, STALL_HEAVY));
      stall_window = $urandom_range(20, 120);
    end
    stall_window--;
    case (stall_style)
      STALL_NONE:     out_stall <= 1'b0;
      STALL_SPARSE:   out_stall <= ($urandom_range(0, 99) < 30);
      STALL_PERIODIC: out_stall <= (stall_window % 5 < 3);
      default:        out_stall <= ($urandom_range(0, 99) < 85);
    endcase
  end

  // --------------------------------------------------------------------------
  // Watchdog: no beat moving on either channel for too long ends the run
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles = 0;

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= StuckLimit) begin
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

[files.f]
design/pida_pkg.sv
design/pida_ctrl.sv
design/pida_dp.sv
design/positional_insert_delete_array.sv
tb/positional_insert_delete_array_tb.sv
